### rtl/atrw_pkg.sv
// Shared types, constants and the decimal conversion for the truecolor colorizer.
package atrw_pkg;

    // Modulus that bounds one random-walk step of a color channel.
    localparam int CHANGE_MODULUS = 16;

    typedef logic [7:0] level_t;

    typedef struct packed {
        level_t red;
        level_t green;
        level_t blue;
    } color_t;

    // Converts an 8-bit value into three BCD digits {hundreds, tens, ones}.
    // The tens digit uses the reciprocal 205/2048, exact for values below 180.
    function automatic logic [11:0] to_dec(input logic [7:0] v);
        logic [1:0]  hund;
        logic [6:0]  rest;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [3:0]  ones;
        if (v >= 8'd200)
        begin
            hund = 2'd2;
            rest = 7'(v - 8'd200);
        end
        else if (v >= 8'd100)
        begin
            hund = 2'd1;
            rest = 7'(v - 8'd100);
        end
        else
        begin
            hund = 2'd0;
            rest = v[6:0];
        end
        prod     = 15'(rest) * 15'd205;
        tens     = 4'(prod >> 11);
        tens_x10 = 7'(7'(tens) * 7'd10);
        ones     = 4'(rest - tens_x10);
        return {2'b00, hund, tens, ones};
    endfunction

endpackage

### rtl/atrw_color.sv
// Next-color logic: reseed from random bytes or take one bounded random-walk step.
module atrw_color
    import atrw_pkg::*;
(
    input  color_t cur,
    input  color_t rnd,
    input  level_t min_level,
    input  level_t max_level,
    output color_t nxt
);

    logic [2:0][7:0] cur_a;
    logic [2:0][7:0] rnd_a;
    logic [2:0][7:0] nxt_a;
    logic            reseed;
    logic [7:0]      rem_tab [256];

    assign cur_a  = cur;
    assign rnd_a  = rnd;
    assign nxt    = nxt_a;
    assign reseed = (cur == '0);

    // Remainder of a magnitude by the step modulus, built at elaboration.
    for (genvar k = 0; k < 256; k++)
    begin : g_rem
        assign rem_tab[k] = 8'(k % CHANGE_MODULUS);
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_chan
        logic [7:0]        mag;
        logic [7:0]        rem;
        logic signed [9:0] step;
        logic signed [9:0] sum;
        logic signed [9:0] hi_lim;
        level_t            seed;
        level_t            walk;

        always_comb
        begin
            // Truncated remainder keeps the sign of the random byte.
            mag    = rnd_a[g][7] ? 8'(-rnd_a[g]) : rnd_a[g];
            rem    = rem_tab[mag];
            step   = rnd_a[g][7] ? -signed'({2'b00, rem}) : signed'({2'b00, rem});
            sum    = signed'({2'b00, cur_a[g]}) + step;
            hi_lim = signed'({2'b00, max_level}) - step;

            if (rnd_a[g] <= min_level)
                seed = min_level;
            else if (rnd_a[g] >= max_level)
                seed = max_level;
            else
                seed = rnd_a[g];

            if (step < 0 && sum < signed'({2'b00, min_level}))
                walk = min_level;
            else if (step > 0 && signed'({2'b00, cur_a[g]}) > hi_lim)
                walk = max_level;
            else
                walk = sum[7:0];

            nxt_a[g] = reseed ? seed : walk;
        end
    end

endmodule

### rtl/ansi_truecolor_random_walk.sv
// Top level of the truecolor random-walk text colorizer.
//
// Requests arrive on the input channel (in_valid / in_stall): a text byte with
// three random bytes, or an end-of-text request (func = 1). A colorable byte
// (0x21..0x7E or 0x80 and up) steps the kept RGB color and produces 20 output
// bytes: ESC [ 3 8 ; 2 ; RRR ; GGG ; BBB m and then the byte itself. Any other
// byte produces itself alone, and an end request produces ESC [ 0 m.
// Output bytes leave one per cycle while out_stall is low, on the output channel
// (out_valid / out_stall); last marks the final byte of each request.
// The first output byte of a request is registered in the sequencer and then
// in the output register. A request holds the sequencer until each of its
// output bytes (1, 4 or 20) has entered the output register. The next
// request is accepted in the same cycle in which the previous request's
// final byte enters the output register, so the output runs without gaps.
// While out_stall is high the output register holds its byte and the
// sequencer waits; in_stall stays high as long as the sequencer holds a request
// whose final byte has not yet moved into the output register.
// Reset clears the color to black, sets the limits to 0 and 255 and empties
// the block. min_level and max_level are written through the cfg port.
module ansi_truecolor_random_walk
    import atrw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       func,
    input  logic [7:0] text_byte,
    input  logic [7:0] rnd_red,
    input  logic [7:0] rnd_green,
    input  logic [7:0] rnd_blue,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last
);

    localparam logic CFG_MIN_LEVEL = 1'b0;
    localparam logic CFG_MAX_LEVEL = 1'b1;

    localparam logic [7:0] CHR_ESC    = 8'h1B;
    localparam logic [7:0] CHR_LBRACK = 8'h5B;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_TWO    = 8'h32;
    localparam logic [7:0] CHR_THREE  = 8'h33;
    localparam logic [7:0] CHR_EIGHT  = 8'h38;
    localparam logic [7:0] CHR_SEMI   = 8'h3B;
    localparam logic [7:0] CHR_M      = 8'h6D;

    localparam logic [4:0] IDX_END_LAST   = 5'd3;
    localparam logic [4:0] IDX_COLOR_LAST = 5'd19;

    // Kind of request held by the sequencer.
    typedef enum logic [2:0] {
        KIND_PASS  = 3'b001,
        KIND_COLOR = 3'b010,
        KIND_END   = 3'b100
    } kind_t;

    level_t     min_level_reg;
    level_t     max_level_reg;
    color_t     level_reg;
    color_t     level_next;
    color_t     rnd_in;

    logic       job_valid_reg;
    kind_t      job_kind_reg;
    kind_t      in_kind;
    logic [7:0] job_text_reg;
    logic [4:0] idx_reg;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    logic       out_load;
    logic       cur_last;
    logic       in_acc;
    logic       colorable;
    logic [7:0] cur_byte;
    level_t     dig_level;
    logic [11:0] dig_bcd;
    logic [3:0] dig_sel;

    assign rnd_in = '{red: rnd_red, green: rnd_green, blue: rnd_blue};

    atrw_color u_color (
        .cur       (level_reg),
        .rnd       (rnd_in),
        .min_level (min_level_reg),
        .max_level (max_level_reg),
        .nxt       (level_next)
    );

    assign colorable = (text_byte >= 8'h80) || (text_byte > 8'h20 && text_byte <= 8'h7E);

    always_comb
    begin
        if (func)
            in_kind = KIND_END;
        else if (colorable)
            in_kind = KIND_COLOR;
        else
            in_kind = KIND_PASS;
    end

    // The sequencer hands a byte to the output register whenever that
    // register is empty or being drained this cycle.
    assign out_load = job_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = job_valid_reg && !(out_load && cur_last);
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        unique case (job_kind_reg)
            KIND_PASS:  cur_last = 1'b1;
            KIND_COLOR: cur_last = (idx_reg == IDX_COLOR_LAST);
            KIND_END:   cur_last = (idx_reg == IDX_END_LAST);
            default:    cur_last = 1'b1;
        endcase
    end

    // Pick the channel whose digits are being sent and the digit within it.
    always_comb
    begin
        case (idx_reg) inside
            5'd7, 5'd8, 5'd9:    dig_level = level_reg.red;
            5'd11, 5'd12, 5'd13: dig_level = level_reg.green;
            default:             dig_level = level_reg.blue;
        endcase
        dig_bcd = to_dec(dig_level);
        case (idx_reg) inside
            5'd7, 5'd11, 5'd15:  dig_sel = dig_bcd[11:8];
            5'd8, 5'd12, 5'd16:  dig_sel = dig_bcd[7:4];
            default:             dig_sel = dig_bcd[3:0];
        endcase
    end

    always_comb
    begin
        unique case (job_kind_reg)
            KIND_END:
            begin
                case (idx_reg)
                    5'd0:    cur_byte = CHR_ESC;
                    5'd1:    cur_byte = CHR_LBRACK;
                    5'd2:    cur_byte = CHR_ZERO;
                    default: cur_byte = CHR_M;
                endcase
            end
            KIND_COLOR:
            begin
                case (idx_reg) inside
                    5'd0:                cur_byte = CHR_ESC;
                    5'd1:                cur_byte = CHR_LBRACK;
                    5'd2:                cur_byte = CHR_THREE;
                    5'd3:                cur_byte = CHR_EIGHT;
                    5'd5:                cur_byte = CHR_TWO;
                    5'd4, 5'd6, 5'd10, 5'd14: cur_byte = CHR_SEMI;
                    5'd18:               cur_byte = CHR_M;
                    5'd19:               cur_byte = job_text_reg;
                    default:             cur_byte = CHR_ZERO | {4'h0, dig_sel};
                endcase
            end
            default: cur_byte = job_text_reg;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_level_reg <= 8'd0;
            max_level_reg <= 8'd255;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_LEVEL: min_level_reg <= cfg_data;
                CFG_MAX_LEVEL: max_level_reg <= cfg_data;
                default:       min_level_reg <= min_level_reg;
            endcase
        end
    end

    // Color state and sequencer. The color is stepped when a colorable
    // request is accepted; the previous request has no digits left by then.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            job_valid_reg <= 1'b0;
            job_kind_reg  <= KIND_PASS;
            idx_reg       <= 5'd0;
        end
        else if (in_acc)
        begin
            job_valid_reg <= 1'b1;
            job_kind_reg  <= in_kind;
            idx_reg       <= 5'd0;
            if (in_kind == KIND_COLOR)
                level_reg <= level_next;
        end
        else if (out_load)
        begin
            if (cur_last)
                job_valid_reg <= 1'b0;
            else
                idx_reg <= 5'(idx_reg + 5'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            job_text_reg <= text_byte;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= cur_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = out_last_reg;

endmodule

### dv/ansi_truecolor_random_walk_tb.sv
// Self-checking testbench for the truecolor random-walk text colorizer.
module ansi_truecolor_random_walk_tb
    import atrw_pkg::*;
();

    // Request kinds on the func field.
    localparam logic FUNC_TEXT = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // Configuration register indexes.
    localparam logic REG_MIN_LEVEL = 1'b0;
    localparam logic REG_MAX_LEVEL = 1'b1;

    localparam logic [7:0] ESC_CHAR   = 8'h1B;
    localparam logic [7:0] DIGIT_ZERO = "0";

    // Random part: nine blocks of requests, each under its own pair of limits.
    localparam int CHUNKS         = 9;
    localparam int CHUNK_ITEMS    = 52;
    localparam int LONG_HOLD      = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 30;

    typedef struct packed {
        logic       func;
        logic [7:0] text_byte;
        logic [7:0] rnd_red;
        logic [7:0] rnd_green;
        logic [7:0] rnd_blue;
    } text_request_t;

    typedef struct packed {
        logic [7:0] code;
        logic       fin;
    } out_char_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_index = REG_MIN_LEVEL;
    logic [7:0] cfg_data  = 8'd0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic       func      = FUNC_TEXT;
    logic [7:0] text_byte = 8'd0;
    logic [7:0] rnd_red   = 8'd0;
    logic [7:0] rnd_green = 8'd0;
    logic [7:0] rnd_blue  = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       last;

    // Requests waiting to be offered, and the bytes the block still owes us.
    text_request_t pending_requests [$];
    out_char_t     expected_chars [$];

    // Private copy of the color state and the limits.
    level_t walk_level [3];
    level_t level_floor;
    level_t level_ceiling;

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int hold_request      = 0;
    int hold_left         = 0;
    int mismatch_count    = 0;
    int results_seen      = 0;
    int quiet_cycles      = 0;

    ansi_truecolor_random_walk dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .text_byte (text_byte),
        .rnd_red   (rnd_red),
        .rnd_green (rnd_green),
        .rnd_blue  (rnd_blue),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

    always #4 clk = ~clk;

    // Every mismatch goes through here: one line, one count.
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("ERROR: %s", what);
    endtask

    function automatic void push_char(input logic [7:0] code, input logic fin);
        out_char_t c;
        c.code = code;
        c.fin  = fin;
        expected_chars.push_back(c);
    endfunction

    // A level appears as three decimal digits, leading zeros kept.
    function automatic void push_level_digits(input level_t v);
        push_char(8'(DIGIT_ZERO + v / 100), 1'b0);
        push_char(8'(DIGIT_ZERO + (v / 10) % 10), 1'b0);
        push_char(8'(DIGIT_ZERO + v % 10), 1'b0);
    endfunction

    function automatic bit wants_color(input logic [7:0] b);
        return (b >= 8'h80) || (b > 8'h20 && b <= 8'h7E);
    endfunction

    // Moves the kept color one step. A black color is reseeded from the random
    // bytes taken as unsigned; otherwise every channel walks by the signed random
    // byte, truncated-remainder by the modulus, and sticks at the limits. The
    // lower limit is tested first, which also settles inverted limits.
    function automatic void step_color(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
        logic [7:0] rnd [3];
        int lo;
        int hi;
        int lvl;
        int d;
        rnd[0] = r;
        rnd[1] = g;
        rnd[2] = b;
        lo = int'(level_floor);
        hi = int'(level_ceiling);
        if (walk_level[0] == 0 && walk_level[1] == 0 && walk_level[2] == 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lvl = int'(rnd[i]);
                if (lvl <= lo)
                    lvl = lo;
                else if (lvl >= hi)
                    lvl = hi;
                walk_level[i] = level_t'(lvl);
            end
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                lvl = int'(walk_level[i]);
                d   = int'($signed(rnd[i])) % CHANGE_MODULUS;
                if (d < 0 && lvl + d < lo)
                    lvl = lo;
                else if (d > 0 && lvl > hi - d)
                    lvl = hi;
                else
                    lvl = lvl + d;
                walk_level[i] = level_t'(lvl);
            end
        end
    endfunction

    // Works out every output byte that one accepted request causes.
    function automatic void colorize_request(input text_request_t req);
        if (req.func == FUNC_END)
        begin
            push_char(ESC_CHAR, 1'b0);
            push_char("[", 1'b0);
            push_char("0", 1'b0);
            push_char("m", 1'b1);
        end
        else if (!wants_color(req.text_byte))
        begin
            push_char(req.text_byte, 1'b1);
        end
        else
        begin
            step_color(req.rnd_red, req.rnd_green, req.rnd_blue);
            push_char(ESC_CHAR, 1'b0);
            push_char("[", 1'b0);
            push_char("3", 1'b0);
            push_char("8", 1'b0);
            push_char(";", 1'b0);
            push_char("2", 1'b0);
            push_char(";", 1'b0);
            push_level_digits(walk_level[0]);
            push_char(";", 1'b0);
            push_level_digits(walk_level[1]);
            push_char(";", 1'b0);
            push_level_digits(walk_level[2]);
            push_char("m", 1'b0);
            push_char(req.text_byte, 1'b1);
        end
    endfunction

    function automatic void queue_request(input logic f, input logic [7:0] t,
                                          input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        text_request_t req;
        req.func      = f;
        req.text_byte = t;
        req.rnd_red   = r;
        req.rnd_green = g;
        req.rnd_blue  = b;
        pending_requests.push_back(req);
    endfunction

    // Random requests are mostly colorable bytes, since those drive the color
    // walk; the rest are end requests and bytes from the whole range.
    function automatic void queue_random_request();
        logic       f;
        logic [7:0] t;
        f = ($urandom_range(0, 9) == 0) ? FUNC_END : FUNC_TEXT;
        if ($urandom_range(0, 3) == 0)
            t = 8'($urandom_range(0, 255));
        else if ($urandom_range(0, 1) == 0)
            t = 8'($urandom_range(8'h21, 8'h7E));
        else
            t = 8'($urandom_range(8'h80, 8'hFF));
        queue_request(f, t, 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // Writes one limit register and updates our copy of it as the write is driven.
    task automatic write_level(input logic idx, input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_MIN_LEVEL)
            level_floor = value;
        else
            level_ceiling = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_limits(input logic [7:0] lo, input logic [7:0] hi);
        write_level(REG_MIN_LEVEL, lo);
        write_level(REG_MAX_LEVEL, hi);
    endtask

    // Blocks until every request has been taken and every byte has come back.
    // Since every request causes at least one byte, the block is idle then.
    task automatic wait_until_drained();
        while (pending_requests.size() != 0 || expected_chars.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
    endtask

    // Sender. A request that is offered stays on the port until it is taken;
    // only between requests may the sender go idle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                colorize_request(pending_requests.pop_front());
            end
            if (in_valid && in_stall)
            begin
                // Hold the stalled request as it is.
            end
            else if (pending_requests.size() != 0 &&
                     $urandom_range(0, 99) >= sender_idle_pct)
            begin
                in_valid  <= 1'b1;
                func      <= pending_requests[0].func;
                text_byte <= pending_requests[0].text_byte;
                rnd_red   <= pending_requests[0].rnd_red;
                rnd_green <= pending_requests[0].rnd_green;
                rnd_blue  <= pending_requests[0].rnd_blue;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver. Checks every byte taken against the oldest expectation, then
    // picks its stall for the next cycle. A hold-off request from the stimulus
    // keeps the stall up for a long stretch so that the block backs up.
    always @(posedge clk)
    begin
        out_char_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d: byte %02h with nothing expected",
                                              results_seen, out_byte));
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_byte !== want.code)
                        report_mismatch($sformatf("result %0d: out_byte %02h, want %02h",
                                                  results_seen, out_byte, want.code));
                    if (last !== want.fin)
                        report_mismatch($sformatf("result %0d: last %b, want %b",
                                                  results_seen, last, want.fin));
                end
                results_seen++;
            end
            if (hold_request != 0)
            begin
                hold_left    = LONG_HOLD;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
            end
        end
    end

    // Watchdog: a long run of cycles with no handshake on either channel and no
    // register write means the block has hung or lost a result.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ansi_truecolor_random_walk: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus. Requests are queued at falling edges so the sender sees a
    // settled queue at the next rising edge.
    initial
    begin
        logic [7:0] lo_pick;
        logic [7:0] hi_pick;
        walk_level[0] = 8'd0;
        walk_level[1] = 8'd0;
        walk_level[2] = 8'd0;
        level_floor   = 8'd0;
        level_ceiling = 8'd255;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        sender_idle_pct   = 34;
        receiver_idle_pct = 77;

        // Bytes that pass alone, and an end request whose other fields are noise.
        queue_request(FUNC_TEXT, 8'h20, 8'h00, 8'h00, 8'h00);
        queue_request(FUNC_TEXT, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        queue_request(FUNC_TEXT, 8'h7F, 8'h12, 8'h34, 8'h56);
        queue_request(FUNC_TEXT, 8'h0A, 8'h80, 8'h80, 8'h80);
        queue_request(FUNC_END,  8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // Reseed from black with zeros keeps it black, so the next one reseeds
        // again, this time from the extremes of the random bytes.
        queue_request(FUNC_TEXT, 8'h21, 8'h00, 8'h00, 8'h00);
        queue_request(FUNC_TEXT, 8'h7E, 8'hFF, 8'h80, 8'h7F);
        // Walk: +15 saturates red at the top, -128 is no change, -15 steps down.
        queue_request(FUNC_TEXT, 8'h80, 8'h7F, 8'h80, 8'hF1);
        queue_request(FUNC_TEXT, 8'hFF, 8'h01, 8'hFF, 8'h10);
        queue_request(FUNC_END,  8'h00, 8'h00, 8'h00, 8'h00);
        wait_until_drained();

        // Inverted limits, with levels left outside them by the write.
        set_limits(8'd200, 8'd50);
        @(negedge clk);
        queue_request(FUNC_TEXT, "A", 8'h05, 8'hFB, 8'h00);
        queue_request(FUNC_TEXT, "z", 8'h9C, 8'h3E, 8'hE7);
        wait_until_drained();

        // A ceiling of zero drags every channel to black, which then reseeds.
        set_limits(8'd0, 8'd0);
        @(negedge clk);
        queue_request(FUNC_TEXT, "a", 8'h0F, 8'h01, 8'h7F);
        queue_request(FUNC_TEXT, "b", 8'h40, 8'h40, 8'h40);
        wait_until_drained();

        // Reseed clamped into a narrow range, then small signed steps.
        set_limits(8'd16, 8'd240);
        @(negedge clk);
        queue_request(FUNC_TEXT, "c", 8'h00, 8'hFF, 8'h80);
        queue_request(FUNC_TEXT, "d", 8'hF0, 8'h8F, 8'h70);

        // Random part. Each block starts only once the block under test is idle,
        // which also makes the sender pause until every byte has come back.
        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            wait_until_drained();
            case (chunk)
                0: begin lo_pick = 8'd0;   hi_pick = 8'd255; end
                1: begin lo_pick = 8'd0;   hi_pick = 8'd0;   end
                2: begin lo_pick = 8'd255; hi_pick = 8'd255; end
                3: begin lo_pick = 8'd255; hi_pick = 8'd0;   end
                4: begin lo_pick = 8'($urandom); hi_pick = 8'($urandom); end
                default:
                begin
                    lo_pick = 8'($urandom_range(0, 127));
                    hi_pick = 8'($urandom_range(128, 255));
                end
            endcase
            set_limits(lo_pick, hi_pick);
            @(negedge clk);
            // Slow sender against a busy receiver, then the reverse, then
            // both running flat out.
            case (chunk / 3)
                0: begin sender_idle_pct = 34; receiver_idle_pct = 77; end
                1: begin sender_idle_pct = 77; receiver_idle_pct = 34; end
                default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
            endcase
            for (int i = 0; i < CHUNK_ITEMS; i++)
            begin
                queue_random_request();
            end
            // With the sender offering requests back to back, a long hold-off
            // on the output fills the block and pushes in_stall up.
            if (chunk == 7)
                hold_request = 1;
        end

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("ansi_truecolor_random_walk: match");
        else
            $display("ansi_truecolor_random_walk: mismatch");
        $finish;
    end

endmodule
